/* src/spsc_pkg.sv */
// Shared types, codes and reset constants for the standby power state controller.
// No dependencies; every other file takes its names from here by scoped reference.
package spsc_pkg;

    // Power states, as presented on power_state
    typedef enum logic [1:0] {
        ST_ACTIVE = 2'd0,
        ST_IDLE   = 2'd1,
        ST_AOD    = 2'd2,
        ST_DEEP   = 2'd3
    } mode_t;

    // Action codes, as presented on action
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_IDLE    = 3'd1,
        ACT_AOD     = 3'd2,
        ACT_DEEP    = 3'd3,
        ACT_WOKE    = 3'd4,
        ACT_REFRESH = 3'd5,
        ACT_SLEEP   = 3'd6
    } action_t;

    // Command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_INTERACT = 3'd1;
    localparam logic [2:0] CMD_WAKE     = 3'd2;
    localparam logic [2:0] CMD_ENABLE   = 3'd3;
    localparam logic [2:0] CMD_DEEP     = 3'd4;

    // Wake reason codes
    localparam logic [2:0] RSN_NONE   = 3'd0;
    localparam logic [2:0] RSN_TOUCH  = 3'd1;
    localparam logic [2:0] RSN_BUTTON = 3'd2;
    localparam logic [2:0] RSN_MOTION = 3'd3;
    localparam logic [2:0] RSN_OTHER  = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_IDLE_AFTER = 3'd0;
    localparam logic [2:0] REG_AOD_AFTER  = 3'd1;
    localparam logic [2:0] REG_DEEP_AFTER = 3'd2;
    localparam logic [2:0] REG_IDLE_PCT   = 3'd3;
    localparam logic [2:0] REG_AOD_PCT    = 3'd4;
    localparam logic [2:0] REG_AGGRESSIVE = 3'd5;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int PCT_W      = 7;
    localparam int BRIGHT_W   = 8;

    localparam int TIMER_WIDTH_DEF = 32;

    // Percent scaling: floor(p / 100) == (p * 5243) >> 19 for every p below 2^15
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int FACTOR_W    = 20;   // 127 * 5243 fits in 20 bits

    localparam logic [CFG_DATA_W-1:0] IDLE_AFTER_RST = 32'd15000;
    localparam logic [CFG_DATA_W-1:0] AOD_AFTER_RST  = 32'd60000;
    localparam logic [CFG_DATA_W-1:0] DEEP_AFTER_RST = 32'd240000;
    localparam logic [FACTOR_W-1:0]   IDLE_FACTOR_RST = FACTOR_W'(30 * RECIP_100);
    localparam logic [FACTOR_W-1:0]   AOD_FACTOR_RST  = FACTOR_W'(5 * RECIP_100);
    localparam logic [BRIGHT_W-1:0]   BRIGHT_RST      = 8'd200;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MIN = 8'd2;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 8'd255;

endpackage

/* src/standby_power_state_controller_top.sv */
// Top level of the standby power state controller: input register, state update, result register.
// Depends on spsc_pkg for state and action types, codes and reset constants.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------------
//  in      | to block  | in_valid / in_stall | command, elapsed_ms, user_brightness,
//          |           |                     | wake_reason, enable_value
//  out     | from block| out_valid/out_stall | power_state, panel_brightness, panel_on,
//          |           |                     | wake_cause, action
//  cfg     | to block  | cfg_we              | cfg_index, cfg_data (write only)
//
// One request per cycle while out_stall is low; each request is taken into the input register,
// and the state update runs from there straight into the result register that offers the result.
// The state update is a single pass of a saturating add, three threshold compares and one 8 x 20
// multiply that scales brightness by a reciprocal of one hundred.
// Reset (rst_n, asynchronous) restores the power-on state and register values.
// A stalled result holds the result register; the input register then stalls in turn.
module standby_power_state_controller_top #(
    parameter int TIMER_WIDTH = spsc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [spsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spsc_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        command,
    input  logic [15:0]                       elapsed_ms,
    input  logic [7:0]                        user_brightness,
    input  logic [2:0]                        wake_reason,
    input  logic                              enable_value,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        power_state,
    output logic [7:0]                        panel_brightness,
    output logic                              panel_on,
    output logic [2:0]                        wake_cause,
    output logic [2:0]                        action
);

    // Compare width: wide enough for the timer and the 32-bit thresholds
    localparam int CMP_W  = (TIMER_WIDTH > spsc_pkg::CFG_DATA_W) ? TIMER_WIDTH
                                                                 : spsc_pkg::CFG_DATA_W;
    localparam int PROD_W = spsc_pkg::BRIGHT_W + spsc_pkg::FACTOR_W;
    localparam int QUOT_W = PROD_W - spsc_pkg::RECIP_SHIFT;

    // Configuration registers; percentages are kept pre-multiplied by the reciprocal
    logic [spsc_pkg::CFG_DATA_W-1:0] idle_after_reg;
    logic [spsc_pkg::CFG_DATA_W-1:0] aod_after_reg;
    logic [spsc_pkg::CFG_DATA_W-1:0] deep_after_reg;
    logic [spsc_pkg::FACTOR_W-1:0]   idle_factor_reg;
    logic [spsc_pkg::FACTOR_W-1:0]   aod_factor_reg;
    logic                            aggressive_reg;

    // Input register
    logic        s1_valid_reg;
    logic [2:0]  s1_cmd_reg;
    logic [15:0] s1_elapsed_reg;
    logic [7:0]  s1_user_reg;
    logic [2:0]  s1_reason_reg;
    logic        s1_en_reg;

    // Controller state
    spsc_pkg::mode_t          mode_reg, mode_next;
    logic [TIMER_WIDTH-1:0]   timer_reg, timer_next;
    logic [7:0]               cache_reg, cache_next;
    logic [2:0]               wake_reg, wake_next;
    logic                     enabled_reg, enabled_next;
    logic                     display_reg, display_next;
    logic [7:0]               drive_reg, drive_next;

    // Result register
    logic        out_valid_reg;
    logic [1:0]  power_state_reg;
    logic [7:0]  panel_brightness_reg;
    logic        panel_on_reg;
    logic [2:0]  wake_cause_reg;
    logic [2:0]  action_reg;

    spsc_pkg::action_t act;

    logic                   in_take;
    logic                   s1_go;
    logic [TIMER_WIDTH:0]   timer_sum;
    logic [TIMER_WIDTH-1:0] timer_sat;
    logic [CMP_W-1:0]       timer_cmp;
    logic                   hit_idle, hit_aod, hit_deep;
    logic                   wake_ok;
    logic [2:0]             wake_code;
    logic [7:0]             scale_base;
    logic [spsc_pkg::FACTOR_W-1:0] scale_factor;
    logic [PROD_W-1:0]      scale_prod;
    logic [QUOT_W-1:0]      scale_quot;
    logic [7:0]             scaled;

    // ------------------------------------------------------------------
    // Handshake: the input register advances whenever the result register
    // is empty or being emptied; stall the input only when both are blocked.
    // ------------------------------------------------------------------
    assign s1_go    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_after_reg  <= spsc_pkg::IDLE_AFTER_RST;
            aod_after_reg   <= spsc_pkg::AOD_AFTER_RST;
            deep_after_reg  <= spsc_pkg::DEEP_AFTER_RST;
            idle_factor_reg <= spsc_pkg::IDLE_FACTOR_RST;
            aod_factor_reg  <= spsc_pkg::AOD_FACTOR_RST;
            aggressive_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spsc_pkg::REG_IDLE_AFTER: idle_after_reg <= cfg_data;
                spsc_pkg::REG_AOD_AFTER:  aod_after_reg  <= cfg_data;
                spsc_pkg::REG_DEEP_AFTER: deep_after_reg <= cfg_data;
                spsc_pkg::REG_IDLE_PCT:
                    idle_factor_reg <= spsc_pkg::FACTOR_W'(
                        cfg_data[spsc_pkg::PCT_W-1:0] * spsc_pkg::FACTOR_W'(spsc_pkg::RECIP_100));
                spsc_pkg::REG_AOD_PCT:
                    aod_factor_reg <= spsc_pkg::FACTOR_W'(
                        cfg_data[spsc_pkg::PCT_W-1:0] * spsc_pkg::FACTOR_W'(spsc_pkg::RECIP_100));
                spsc_pkg::REG_AGGRESSIVE: aggressive_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture a new request, drop the old one as it advances
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg     <= command;
            s1_elapsed_reg <= elapsed_ms;
            s1_user_reg    <= user_brightness;
            s1_reason_reg  <= wake_reason;
            s1_en_reg      <= enable_value;
        end
    end

    // ------------------------------------------------------------------
    // Datapath shared by next-state and output logic
    // ------------------------------------------------------------------
    // Saturating idle timer; elapsed_ms never exceeds the timer range
    assign timer_sum = {1'b0, timer_reg} + (TIMER_WIDTH + 1)'(s1_elapsed_reg);
    assign timer_sat = timer_sum[TIMER_WIDTH] ? {TIMER_WIDTH{1'b1}}
                                              : timer_sum[TIMER_WIDTH-1:0];
    assign timer_cmp = CMP_W'(timer_sat);
    assign hit_idle  = timer_cmp >= CMP_W'(idle_after_reg);
    assign hit_aod   = timer_cmp >= CMP_W'(aod_after_reg);
    assign hit_deep  = timer_cmp >= CMP_W'(deep_after_reg);

    // Among wake reasons, only touch, button and motion leave AOD for ACTIVE
    always_comb
    begin
        wake_ok = s1_reason_reg inside {spsc_pkg::RSN_TOUCH, spsc_pkg::RSN_BUTTON,
                                        spsc_pkg::RSN_MOTION};
    end

    // Brightness scaling: from ACTIVE it dims the freshly captured user value,
    // from IDLE it dims the cached value for AOD. Clamp to 2..255.
    assign scale_base   = (mode_reg == spsc_pkg::ST_ACTIVE) ? s1_user_reg : cache_reg;
    assign scale_factor = (mode_reg == spsc_pkg::ST_ACTIVE) ? idle_factor_reg : aod_factor_reg;
    assign scale_prod   = PROD_W'(scale_base) * PROD_W'(scale_factor);
    assign scale_quot   = scale_prod[PROD_W-1:spsc_pkg::RECIP_SHIFT];

    always_comb
    begin
        if (scale_quot < QUOT_W'(spsc_pkg::BRIGHT_MIN))
            scaled = spsc_pkg::BRIGHT_MIN;
        else if (scale_quot > QUOT_W'(spsc_pkg::BRIGHT_MAX))
            scaled = spsc_pkg::BRIGHT_MAX;
        else
            scaled = scale_quot[7:0];
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next = mode_reg;
        case (s1_cmd_reg)
            spsc_pkg::CMD_TICK:
            begin
                if (enabled_reg)
                begin
                    case (mode_reg)
                        spsc_pkg::ST_ACTIVE:
                            if (hit_idle)
                                mode_next = aggressive_reg ? spsc_pkg::ST_DEEP
                                                           : spsc_pkg::ST_IDLE;
                        spsc_pkg::ST_IDLE:
                            if (hit_aod)
                                mode_next = spsc_pkg::ST_AOD;
                        spsc_pkg::ST_AOD:
                            if (hit_deep)
                                mode_next = spsc_pkg::ST_DEEP;
                        default: ;
                    endcase
                end
            end
            spsc_pkg::CMD_INTERACT:
                mode_next = spsc_pkg::ST_ACTIVE;
            spsc_pkg::CMD_WAKE:
            begin
                if (mode_reg == spsc_pkg::ST_DEEP ||
                    (mode_reg == spsc_pkg::ST_AOD && wake_ok))
                    mode_next = spsc_pkg::ST_ACTIVE;
            end
            spsc_pkg::CMD_ENABLE:
            begin
                if (!s1_en_reg)
                    mode_next = spsc_pkg::ST_ACTIVE;
            end
            spsc_pkg::CMD_DEEP:
                mode_next = spsc_pkg::ST_DEEP;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs: action code and the data state that follows from it
    // ------------------------------------------------------------------
    always_comb
    begin
        act       = spsc_pkg::ACT_NONE;
        wake_code = spsc_pkg::RSN_NONE;
        case (s1_cmd_reg)
            spsc_pkg::CMD_TICK:
            begin
                if (enabled_reg)
                begin
                    case (mode_reg)
                        spsc_pkg::ST_ACTIVE:
                            if (hit_idle)
                                act = aggressive_reg ? spsc_pkg::ACT_DEEP : spsc_pkg::ACT_IDLE;
                        spsc_pkg::ST_IDLE:
                            if (hit_aod)
                                act = spsc_pkg::ACT_AOD;
                        spsc_pkg::ST_AOD:
                            act = hit_deep ? spsc_pkg::ACT_DEEP : spsc_pkg::ACT_SLEEP;
                        default: ;
                    endcase
                end
            end
            spsc_pkg::CMD_INTERACT:
            begin
                wake_code = spsc_pkg::RSN_TOUCH;
                if (mode_reg != spsc_pkg::ST_ACTIVE)
                    act = spsc_pkg::ACT_WOKE;
            end
            spsc_pkg::CMD_WAKE:
            begin
                wake_code = s1_reason_reg;
                if (mode_reg == spsc_pkg::ST_DEEP)
                    act = spsc_pkg::ACT_WOKE;
                else if (mode_reg == spsc_pkg::ST_AOD)
                    act = wake_ok ? spsc_pkg::ACT_WOKE : spsc_pkg::ACT_REFRESH;
            end
            spsc_pkg::CMD_ENABLE:
            begin
                wake_code = spsc_pkg::RSN_OTHER;
                if (!s1_en_reg && mode_reg != spsc_pkg::ST_ACTIVE)
                    act = spsc_pkg::ACT_WOKE;
            end
            spsc_pkg::CMD_DEEP:
                act = spsc_pkg::ACT_DEEP;
            default: ;
        endcase
    end

    always_comb
    begin
        timer_next   = timer_reg;
        cache_next   = cache_reg;
        wake_next    = wake_reg;
        enabled_next = enabled_reg;
        display_next = display_reg;
        drive_next   = drive_reg;

        // Ticks always advance the timer, even when disabled
        if (s1_cmd_reg == spsc_pkg::CMD_TICK)
            timer_next = timer_sat;
        if (s1_cmd_reg == spsc_pkg::CMD_INTERACT)
            timer_next = '0;
        if (s1_cmd_reg == spsc_pkg::CMD_ENABLE)
            enabled_next = s1_en_reg;

        case (act)
            spsc_pkg::ACT_IDLE:
            begin
                cache_next = s1_user_reg;
                drive_next = scaled;
            end
            spsc_pkg::ACT_AOD:
                drive_next = scaled;
            spsc_pkg::ACT_DEEP:
                display_next = 1'b0;   // brightness keeps its last value
            spsc_pkg::ACT_WOKE:
            begin
                display_next = 1'b1;
                drive_next   = cache_reg;
                wake_next    = wake_code;
                timer_next   = '0;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // State registers: advance once per request leaving the input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= spsc_pkg::ST_ACTIVE;
            timer_reg   <= '0;
            cache_reg   <= spsc_pkg::BRIGHT_RST;
            wake_reg    <= spsc_pkg::RSN_NONE;
            enabled_reg <= 1'b1;
            display_reg <= 1'b1;
            drive_reg   <= spsc_pkg::BRIGHT_RST;
        end
        else if (s1_go)
        begin
            mode_reg    <= mode_next;
            timer_reg   <= timer_next;
            cache_reg   <= cache_next;
            wake_reg    <= wake_next;
            enabled_reg <= enabled_next;
            display_reg <= display_next;
            drive_reg   <= drive_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on advance, hold while stalled
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            power_state_reg      <= mode_next;
            panel_brightness_reg <= drive_next;
            panel_on_reg         <= display_next;
            wake_cause_reg       <= wake_next;
            action_reg           <= act;
        end
    end

    assign out_valid        = out_valid_reg;
    assign power_state      = power_state_reg;
    assign panel_brightness = panel_brightness_reg;
    assign panel_on         = panel_on_reg;
    assign wake_cause       = wake_cause_reg;
    assign action           = action_reg;

endmodule

/* dv/tb_standby_power_state_controller_top.sv */
// Self-checking testbench for standby_power_state_controller_top: directed and random requests.
// A scoreboard class predicts each result from the accepted request and the register settings.
// Depends on spsc_pkg and the top level only.
module tb_standby_power_state_controller_top;

    // Wake codes with no name in the package: timer, and the two codes above other
    localparam logic [2:0] RSN_TIMER    = 3'd4;
    localparam logic [2:0] WAKE_SPARE_A = 3'd6;
    localparam logic [2:0] WAKE_SPARE_B = 3'd7;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [31:0] AFTER_MAX   = 32'hFFFF_FFFF;

    // One result as the panel sees it
    typedef struct packed {
        spsc_pkg::mode_t   power;
        logic [7:0]        bright;
        logic              on;
        logic [2:0]        wake;
        spsc_pkg::action_t act;
    } panel_result_t;

    // Tracks the controller state and the result each accepted request must produce
    class power_scoreboard;
        logic [31:0]     idle_after, aod_after, deep_after;
        logic [6:0]      idle_pct, aod_pct;
        logic            aggressive;
        spsc_pkg::mode_t mode;
        logic [31:0]     idle_timer;
        logic [7:0]      cache, drive;
        logic [2:0]      wake_rec;
        logic            enabled, display;
        panel_result_t   wanted_q[$];
        int              errors;

        function new();
            idle_after = spsc_pkg::IDLE_AFTER_RST;
            aod_after  = spsc_pkg::AOD_AFTER_RST;
            deep_after = spsc_pkg::DEEP_AFTER_RST;
            idle_pct   = 7'd30;
            aod_pct    = 7'd5;
            aggressive = 1'b0;
            mode       = spsc_pkg::ST_ACTIVE;
            idle_timer = '0;
            cache      = spsc_pkg::BRIGHT_RST;
            drive      = spsc_pkg::BRIGHT_RST;
            wake_rec   = spsc_pkg::RSN_NONE;
            enabled    = 1'b1;
            display    = 1'b1;
            errors     = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                spsc_pkg::REG_IDLE_AFTER: idle_after = data;
                spsc_pkg::REG_AOD_AFTER:  aod_after  = data;
                spsc_pkg::REG_DEEP_AFTER: deep_after = data;
                spsc_pkg::REG_IDLE_PCT:   idle_pct   = data[6:0];
                spsc_pkg::REG_AOD_PCT:    aod_pct    = data[6:0];
                spsc_pkg::REG_AGGRESSIVE: aggressive = data[0];
                default: ;
            endcase
        endfunction

        // Brightness times percent over a hundred, held within 2..255
        function logic [7:0] scale(logic [7:0] base, logic [6:0] pct);
            int unsigned v;
            v = (32'(base) * 32'(pct)) / 100;
            if (v < 2) v = 2;
            if (v > 255) v = 255;
            return v[7:0];
        endfunction

        function spsc_pkg::action_t go_active(logic [2:0] reason);
            display    = 1'b1;
            drive      = cache;
            mode       = spsc_pkg::ST_ACTIVE;
            wake_rec   = reason;
            idle_timer = '0;
            return spsc_pkg::ACT_WOKE;
        endfunction

        function spsc_pkg::action_t go_deep();
            mode    = spsc_pkg::ST_DEEP;
            display = 1'b0;
            return spsc_pkg::ACT_DEEP;
        endfunction

        function void note_request(logic [2:0] c, logic [15:0] e, logic [7:0] u,
                                   logic [2:0] r, logic en);
            logic [32:0]       sum;
            spsc_pkg::action_t act;
            panel_result_t     res;
            act = spsc_pkg::ACT_NONE;
            case (c)
                spsc_pkg::CMD_TICK:
                begin
                    // Timer runs even when disabled, and sticks at all ones
                    sum = {1'b0, idle_timer} + 33'(e);
                    idle_timer = sum[32] ? '1 : sum[31:0];
                    if (enabled)
                    begin
                        case (mode)
                            spsc_pkg::ST_ACTIVE:
                                if (idle_timer >= idle_after)
                                begin
                                    if (aggressive)
                                        act = go_deep();
                                    else
                                    begin
                                        mode  = spsc_pkg::ST_IDLE;
                                        cache = u;
                                        drive = scale(cache, idle_pct);
                                        act   = spsc_pkg::ACT_IDLE;
                                    end
                                end
                            spsc_pkg::ST_IDLE:
                                if (idle_timer >= aod_after)
                                begin
                                    mode  = spsc_pkg::ST_AOD;
                                    drive = scale(cache, aod_pct);
                                    act   = spsc_pkg::ACT_AOD;
                                end
                            spsc_pkg::ST_AOD:
                                if (idle_timer >= deep_after)
                                    act = go_deep();
                                else
                                    act = spsc_pkg::ACT_SLEEP;
                            default: ;
                        endcase
                    end
                end
                spsc_pkg::CMD_INTERACT:
                begin
                    idle_timer = '0;
                    if (mode != spsc_pkg::ST_ACTIVE)
                        act = go_active(spsc_pkg::RSN_TOUCH);
                end
                spsc_pkg::CMD_WAKE:
                    if (mode == spsc_pkg::ST_DEEP ||
                        (mode == spsc_pkg::ST_AOD &&
                         r inside {spsc_pkg::RSN_TOUCH, spsc_pkg::RSN_BUTTON,
                                   spsc_pkg::RSN_MOTION}))
                        act = go_active(r);
                    else if (mode == spsc_pkg::ST_AOD)
                        act = spsc_pkg::ACT_REFRESH;
                spsc_pkg::CMD_ENABLE:
                begin
                    enabled = en;
                    if (!en && mode != spsc_pkg::ST_ACTIVE)
                        act = go_active(spsc_pkg::RSN_OTHER);
                end
                spsc_pkg::CMD_DEEP:
                    act = go_deep();
                default: ;
            endcase
            res = '{mode, drive, display, wake_rec, act};
            wanted_q.push_back(res);
        endfunction

        function int pending();
            return wanted_q.size();
        endfunction

        function void compare_field(string name, logic [7:0] wanted, logic [7:0] seen);
            if (seen !== wanted)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, wanted, seen);
            end
        endfunction

        function void check_result(logic [1:0] ps, logic [7:0] pb, logic po,
                                   logic [2:0] lw, logic [2:0] ac);
            panel_result_t w;
            if (wanted_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding: expected none, actual %0d/%0d",
                         $time, ps, ac);
                return;
            end
            w = wanted_q.pop_front();
            compare_field("power_state", w.power, ps);
            compare_field("panel_brightness", w.bright, pb);
            compare_field("panel_on", w.on, po);
            compare_field("wake_cause", w.wake, lw);
            compare_field("action", w.act, ac);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = '0;
    logic [15:0] elapsed_ms = '0;
    logic [7:0]  user_brightness = '0;
    logic [2:0]  wake_reason = '0;
    logic        enable_value = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  power_state;
    logic [7:0]  panel_brightness;
    logic        panel_on;
    logic [2:0]  wake_cause;
    logic [2:0]  action;

    // Set for a stretch of the run in which neither side idles
    bit steady = 1'b0;

    power_scoreboard sb = new();

    standby_power_state_controller_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .elapsed_ms       (elapsed_ms),
        .user_brightness  (user_brightness),
        .wake_reason      (wake_reason),
        .enable_value     (enable_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .power_state      (power_state),
        .panel_brightness (panel_brightness),
        .panel_on         (panel_on),
        .wake_cause       (wake_cause),
        .action           (action)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Stall the result side at random, with a chance of seven in a hundred, except in the steady stretch
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 7);

    // Check every result taken at this edge; all values read here are the pre-edge ones
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(power_state, panel_brightness, panel_on, wake_cause, action);

    // Offer one request, idling first now and then, and hold it until the block takes it
    task automatic send_request(input logic [2:0] c, input logic [15:0] e,
                                input logic [7:0] u, input logic [2:0] r, input logic en);
        while (!steady && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= c;
        elapsed_ms      <= e;
        user_brightness <= u;
        wake_reason     <= r;
        enable_value    <= en;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(c, e, u, r, en);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    // Load all six registers while the block is empty
    task automatic load_settings(input logic [31:0] idle_after, input logic [31:0] aod_after,
                                 input logic [31:0] deep_after, input logic [31:0] idle_pct,
                                 input logic [31:0] aod_pct, input logic [31:0] aggr);
        drain_results();
        write_register(spsc_pkg::REG_IDLE_AFTER, idle_after);
        write_register(spsc_pkg::REG_AOD_AFTER, aod_after);
        write_register(spsc_pkg::REG_DEEP_AFTER, deep_after);
        write_register(spsc_pkg::REG_IDLE_PCT, idle_pct);
        write_register(spsc_pkg::REG_AOD_PCT, aod_pct);
        write_register(spsc_pkg::REG_AGGRESSIVE, aggr);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly ticks so that the state walks down through the levels, mixed with
    // interactions, wakes, enables, forced deep sleep and the unused codes
    task automatic send_random_requests(input int count);
        int          pick;
        logic [2:0]  c;
        logic [15:0] e;
        // Re-enable at the start so that each setting gets to move the state
        send_request(spsc_pkg::CMD_ENABLE, 16'($urandom), 8'($urandom), 3'($urandom), 1'b1);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 58)
                c = spsc_pkg::CMD_TICK;
            else if (pick < 64)
                c = spsc_pkg::CMD_INTERACT;
            else if (pick < 78)
                c = spsc_pkg::CMD_WAKE;
            else if (pick < 86)
                c = spsc_pkg::CMD_ENABLE;
            else if (pick < 94)
                c = spsc_pkg::CMD_DEEP;
            else
                c = spsc_pkg::CMD_DEEP + 3'($urandom_range(1, 3));   // codes past deep now
            case ($urandom_range(0, 9))
                0: e = '0;
                1: e = ELAPSED_MAX;
                2, 3, 4, 5: e = 16'($urandom);
                default: e = 16'($urandom_range(0, 2000));
            endcase
            send_request(c, e, 8'($urandom), 3'($urandom), $urandom_range(0, 3) != 0);
        end
    endtask

    initial
    begin
        // Hold reset at the start, once only
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with the reset settings: 15000 / 60000 / 240000 ms, 30 % and 5 %
        send_request(spsc_pkg::CMD_TICK, 16'd0, 8'd17, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_TICK, ELAPSED_MAX, 8'd255, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_WAKE, 16'd0, 8'd0, spsc_pkg::RSN_TOUCH, 1'b0);  // ignored
        send_request(spsc_pkg::CMD_TICK, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);   // to aod
        send_request(spsc_pkg::CMD_TICK, 16'd1000, 8'd0, spsc_pkg::RSN_NONE, 1'b0); // light sleep
        send_request(spsc_pkg::CMD_WAKE, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);   // refresh
        send_request(spsc_pkg::CMD_WAKE, 16'd0, 8'd0, RSN_TIMER, 1'b0);
        send_request(spsc_pkg::CMD_WAKE, 16'd0, 8'd0, WAKE_SPARE_B, 1'b0);
        send_request(spsc_pkg::CMD_WAKE, 16'd0, 8'd0, spsc_pkg::RSN_MOTION, 1'b0); // to active
        send_request(spsc_pkg::CMD_INTERACT, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_DEEP, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_TICK, ELAPSED_MAX, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_DEEP, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);   // deep again
        send_request(spsc_pkg::CMD_WAKE, 16'd0, 8'd0, WAKE_SPARE_A, 1'b0);  // odd reboot reason
        send_request(spsc_pkg::CMD_DEEP + 3'd1, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_DEEP + 3'd3, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_ENABLE, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_TICK, ELAPSED_MAX, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_ENABLE, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b1);
        send_request(spsc_pkg::CMD_TICK, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);   // floor
        send_request(spsc_pkg::CMD_ENABLE, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_ENABLE, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b1);
        send_request(spsc_pkg::CMD_DEEP, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        send_request(spsc_pkg::CMD_INTERACT, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        for (int n = 0; n < 4; n++)                                     // idle, aod, sleep, deep
            send_request(spsc_pkg::CMD_TICK, ELAPSED_MAX, 8'd99, spsc_pkg::RSN_NONE, 1'b0);

        // Thresholds at their top: a run of full ticks builds a large timer
        // that stays below them, so the state never moves
        load_settings(AFTER_MAX, AFTER_MAX, AFTER_MAX, 32'd30, 32'd5, 32'd0);
        send_request(spsc_pkg::CMD_INTERACT, 16'd0, 8'd0, spsc_pkg::RSN_NONE, 1'b0);
        for (int n = 0; n < 40; n++)
            send_request(spsc_pkg::CMD_TICK, ELAPSED_MAX, 8'($urandom), spsc_pkg::RSN_NONE,
                         1'b0);

        // Random phases over a spread of settings, extremes among them
        load_settings(32'd1000, 32'd5000, 32'd20000, 32'd100, 32'd127, 32'd0);
        send_random_requests(265);
        load_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_random_requests(265);
        load_settings(32'd40000, 32'd90000, 32'd150000, 32'd127, 32'd50, 32'd1);
        send_random_requests(265);
        // Full-width data on the narrow registers: only the low bits count
        load_settings($urandom_range(0, 200000), $urandom_range(0, 200000),
                      $urandom_range(0, 300000), $urandom, $urandom, $urandom);
        send_random_requests(265);
        // Long stretch with neither side idling
        steady = 1'b1;
        load_settings(spsc_pkg::IDLE_AFTER_RST, spsc_pkg::AOD_AFTER_RST,
                      spsc_pkg::DEEP_AFTER_RST, 32'd30, 32'd5, 32'd0);
        send_random_requests(265);
        steady = 1'b0;
        // Thresholds out of order
        load_settings(32'd300, 32'd200, 32'd100, 32'd1, 32'd99, 32'd0);
        send_random_requests(265);

        // Let the last results arrive, then allow a little longer for strays
        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Stop a hung run; the slowest correct run needs well under a tenth of this
    initial
    begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
